@@ src/image_rotation_remap_defines.svh @@
// Assertion macros shared by the image rotation remap checker.
`ifndef IMAGE_ROTATION_REMAP_DEFINES_SVH
`define IMAGE_ROTATION_REMAP_DEFINES_SVH

// Check that cons holds in every cycle where ante holds, outside reset.
`define IRR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("image rotation remap: implication check failed");

// Check that expr never holds outside reset.
`define IRR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("image rotation remap: forbidden condition seen");

`endif

@@ src/irr_pkg.sv @@
// Types and constants shared by the image rotation remap modules.
package irr_pkg;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned RGBA_W     = 32;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  // doubled, centred coordinate: 2*coord - dim
  localparam int unsigned DBL_W      = DIM_W + 1;
  localparam int unsigned PROD_W     = DBL_W + TRIG_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3
  } irr_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [RGBA_W-1:0]  pixel_rgba;
  } irr_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [RGBA_W-1:0]  out_rgba;
  } irr_out_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_value;
    logic signed [TRIG_W-1:0] sin_value;
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
  } irr_cfg_t;

endpackage

@@ src/image_rotation_remap.sv @@
// Top level of the nearest-neighbor image rotation remapper.
//
//   channel  | handshake          | payload       | notes
//   ---------+--------------------+---------------+------------------------------
//   input    | start_i, busy_o    | in_i          | taken when start_i && !busy_o
//   result   | res_valid_o        | res_o         | one-cycle strobe, zero or one
//   config   | cfg_we_i           | cfg_idx_i,    | written on every edge with
//            |                    | cfg_wdata_i   | cfg_we_i high
//
// One item enters per cycle; busy_o stays low. Each item passes the input register,
// the rotation register (four 12x16 products and the sums) and the result register
// (truncation and bounds compare).
// Reset clears the valid flags and loads the identity rotation on a 64x64 image.
// The result side cannot stall, so nothing holds the pipeline.
module image_rotation_remap #(
  parameter int unsigned DIM_BITS  = 10,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  irr_pkg::irr_in_t                  in_i,
  input  logic                              cfg_we_i,
  input  logic [irr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [irr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                              res_valid_o,
  output irr_pkg::irr_out_t                 res_o
);
  import irr_pkg::*;

  // Sum width: room for the products, the center offset and the bounds compare
  localparam int unsigned W_A   = PROD_W + 1;
  localparam int unsigned W_B   = FRAC_BITS + DBL_W;
  localparam int unsigned W_C   = FRAC_BITS + DIM_BITS + 3;
  localparam int unsigned W_D   = FRAC_BITS + DIM_W + 2;
  localparam int unsigned W_AB  = (W_A > W_B) ? W_A : W_B;
  localparam int unsigned W_CD  = (W_C > W_D) ? W_C : W_D;
  localparam int unsigned SUM_W = ((W_AB > W_CD) ? W_AB : W_CD) + 2;

  irr_cfg_t                cfg_q;
  irr_in_t                 in_q;
  logic                    in_vld_q;
  logic                    rot_vld;
  logic signed [SUM_W-1:0] nx, ny;
  logic [RGBA_W-1:0]       rot_rgba;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_value    <= TRIG_W'(16'sd16384);
      cfg_q.sin_value    <= '0;
      cfg_q.image_width  <= DIM_W'(64);
      cfg_q.image_height <= DIM_W'(64);
    end else if (cfg_we_i) begin
      unique case (irr_reg_e'(cfg_idx_i))
        REG_COS:    cfg_q.cos_value    <= $signed(cfg_wdata_i[TRIG_W-1:0]);
        REG_SIN:    cfg_q.sin_value    <= $signed(cfg_wdata_i[TRIG_W-1:0]);
        REG_WIDTH:  cfg_q.image_width  <= cfg_wdata_i[DIM_W-1:0];
        REG_HEIGHT: cfg_q.image_height <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Track input item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    in_q <= in_i;
  end

  irr_rotate #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .valid_o (rot_vld),
    .nx_o    (nx),
    .ny_o    (ny),
    .rgba_o  (rot_rgba)
  );

  irr_bounds #(
    .FRAC_BITS (FRAC_BITS),
    .DIM_BITS  (DIM_BITS),
    .SUM_W     (SUM_W)
  ) u_bounds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (rot_vld),
    .nx_i        (nx),
    .ny_i        (ny),
    .rgba_i      (rot_rgba),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ src/irr_rotate.sv @@
// Rotation stage: centered doubled coordinates times cos/sin, plus the center offset.
module irr_rotate #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned SUM_W     = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  irr_pkg::irr_in_t            item_i,
  input  irr_pkg::irr_cfg_t           cfg_i,
  output logic                        valid_o,
  output logic signed [SUM_W-1:0]     nx_o,
  output logic signed [SUM_W-1:0]     ny_o,
  output logic [irr_pkg::RGBA_W-1:0]  rgba_o
);
  import irr_pkg::*;

  logic signed [DBL_W-1:0]  dx2, dy2;
  logic signed [PROD_W-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [SUM_W-1:0]  off_x, off_y;
  logic signed [SUM_W-1:0]  nx_d, ny_d;
  logic signed [SUM_W-1:0]  nx_q, ny_q;
  logic [RGBA_W-1:0]        rgba_q;
  logic                     valid_q;

  // Center the doubled coordinates
  assign dx2 = $signed({1'b0, item_i.src_x, 1'b0}) - $signed({1'b0, cfg_i.image_width});
  assign dy2 = $signed({1'b0, item_i.src_y, 1'b0}) - $signed({1'b0, cfg_i.image_height});

  // Four small products in parallel
  assign p_xc = dx2 * cfg_i.cos_value;
  assign p_ys = dy2 * cfg_i.sin_value;
  assign p_xs = dx2 * cfg_i.sin_value;
  assign p_yc = dy2 * cfg_i.cos_value;

  // Move the origin back to the image center, in Q.FRAC_BITS
  assign off_x = $signed(SUM_W'({1'b0, cfg_i.image_width}) << FRAC_BITS);
  assign off_y = $signed(SUM_W'({1'b0, cfg_i.image_height}) << FRAC_BITS);

  assign nx_d = SUM_W'(p_xc) - SUM_W'(p_ys) + off_x;
  assign ny_d = SUM_W'(p_xs) + SUM_W'(p_yc) + off_y;

  // Track item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the rotated sums
  always_ff @(posedge clk_i) begin
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    rgba_q <= item_i.pixel_rgba;
  end

  assign valid_o = valid_q;
  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign rgba_o  = rgba_q;

endmodule

@@ src/irr_bounds.sv @@
// Bounds stage: truncate toward zero, drop points outside the image, register the result.
module irr_bounds #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned DIM_BITS  = 10,
  parameter int unsigned SUM_W     = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [SUM_W-1:0]     nx_i,
  input  logic signed [SUM_W-1:0]     ny_i,
  input  logic [irr_pkg::RGBA_W-1:0]  rgba_i,
  input  irr_pkg::irr_cfg_t           cfg_i,
  output logic                        res_valid_o,
  output irr_pkg::irr_out_t           res_o
);
  import irr_pkg::*;

  localparam int unsigned Q_W = SUM_W - FRAC_BITS - 1;
  localparam logic signed [Q_W-1:0] LIM = Q_W'(1) << DIM_BITS;

  logic signed [Q_W-1:0] qx, qy, wq, hq;
  logic                  inc_x, inc_y;
  logic                  in_x, in_y;
  logic                  res_valid_q;
  irr_out_t              res_q;

  // Floor shift, then step up one for a negative value with a nonzero fraction
  assign inc_x = nx_i[SUM_W-1] & (|nx_i[FRAC_BITS:0]);
  assign inc_y = ny_i[SUM_W-1] & (|ny_i[FRAC_BITS:0]);
  assign qx = $signed(nx_i[SUM_W-1:FRAC_BITS+1]) + $signed({{(Q_W-1){1'b0}}, inc_x});
  assign qy = $signed(ny_i[SUM_W-1:FRAC_BITS+1]) + $signed({{(Q_W-1){1'b0}}, inc_y});

  assign wq = $signed({{(Q_W-DIM_W){1'b0}}, cfg_i.image_width});
  assign hq = $signed({{(Q_W-DIM_W){1'b0}}, cfg_i.image_height});

  // Keep only points inside both the image and the coordinate range
  assign in_x = !qx[Q_W-1] && (qx < wq) && (qx < LIM);
  assign in_y = !qy[Q_W-1] && (qy < hq) && (qy < LIM);

  // Strobe a result for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_i && in_x && in_y;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    res_q.dest_x   <= qx[COORD_W-1:0];
    res_q.dest_y   <= qy[COORD_W-1:0];
    res_q.out_rgba <= rgba_i;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ src/irr_checker.sv @@
// Port-level checks for the image rotation remapper, bound to its top level.
`include "image_rotation_remap_defines.svh"

module irr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input irr_pkg::irr_in_t               in_i,
  input logic                           res_valid_o,
  input irr_pkg::irr_out_t              res_o
);
  import irr_pkg::*;

  // Every item is taken: the block never pushes back
  `IRR_ASSERT_NEVER(busy_never_high, busy_o)

  // A result always traces back to an item that was taken at the input
  `IRR_ASSERT_IMPL(res_has_source, res_valid_o, $past(start_i && !busy_o, 3))

  // The pixel word passes through unchanged
  `IRR_ASSERT_IMPL(rgba_passes, res_valid_o, res_o.out_rgba == $past(in_i.pixel_rgba, 3))

endmodule

bind image_rotation_remap irr_checker u_irr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .in_i        (in_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
